/* rtl/arp_pkg.sv */
// shared types, register codes and ratio pattern tables for the arpeggio ratio stepper
package arp_pkg;

	typedef enum logic [0:0] {
		REG_PATTERN_SELECT = 1'b0,
		REG_STEP_DURATION  = 1'b1
	} arp_reg_t;

	localparam logic [15:0] STEP_DURATION_RESET = 16'd1000;

	typedef struct packed {
		logic signed [31:0] sample;
		logic [2:0]         factor;
		logic [1:0]         shift;
		logic [1:0]         step;
	} arp_op_t;

	function automatic logic [2:0] pat_len(input logic [2:0] sel);
		logic [2:0] len;
		case (sel)
			3'd0:    len = 3'd1;
			3'd1:    len = 3'd2;
			3'd2:    len = 3'd2;
			3'd3:    len = 3'd3;
			3'd4:    len = 3'd3;
			default: len = 3'd4;
		endcase
		return len;
	endfunction

	function automatic logic [2:0] pat_mul(input logic [2:0] sel, input logic [1:0] step);
		logic [2:0] mul;
		case ({sel, step})
			{3'd0, 2'd0}: mul = 3'd1;
			{3'd1, 2'd0}: mul = 3'd1;
			{3'd1, 2'd1}: mul = 3'd2;
			{3'd2, 2'd0}: mul = 3'd1;
			{3'd2, 2'd1}: mul = 3'd3;
			{3'd3, 2'd0}: mul = 3'd1;
			{3'd3, 2'd1}: mul = 3'd2;
			{3'd3, 2'd2}: mul = 3'd4;
			{3'd4, 2'd0}: mul = 3'd1;
			{3'd4, 2'd1}: mul = 3'd3;
			{3'd4, 2'd2}: mul = 3'd2;
			{3'd5, 2'd0}: mul = 3'd1;
			{3'd5, 2'd1}: mul = 3'd3;
			{3'd5, 2'd2}: mul = 3'd2;
			{3'd5, 2'd3}: mul = 3'd3;
			{3'd6, 2'd0}: mul = 3'd1;
			{3'd6, 2'd1}: mul = 3'd3;
			{3'd6, 2'd2}: mul = 3'd2;
			{3'd6, 2'd3}: mul = 3'd3;
			{3'd7, 2'd0}: mul = 3'd1;
			{3'd7, 2'd1}: mul = 3'd5;
			{3'd7, 2'd2}: mul = 3'd3;
			{3'd7, 2'd3}: mul = 3'd2;
			default:      mul = 3'd0;
		endcase
		return mul;
	endfunction

	function automatic logic [1:0] pat_shr(input logic [2:0] sel, input logic [1:0] step);
		logic [1:0] shr;
		case ({sel, step})
			{3'd2, 2'd1}: shr = 2'd1;
			{3'd4, 2'd1}: shr = 2'd1;
			{3'd5, 2'd1}: shr = 2'd1;
			{3'd5, 2'd3}: shr = 2'd1;
			{3'd6, 2'd1}: shr = 2'd1;
			{3'd7, 2'd1}: shr = 2'd2;
			{3'd7, 2'd2}: shr = 2'd1;
			default:      shr = 2'd0;
		endcase
		return shr;
	endfunction

	// step reduced modulo a pattern length of one to four
	function automatic logic [1:0] step_mod(input logic [1:0] step, input logic [2:0] len);
		logic [1:0] r;
		case (len)
			3'd1:    r = 2'd0;
			3'd2:    r = {1'b0, step[0]};
			3'd3:    r = (step == 2'd3) ? 2'd0 : step;
			default: r = step;
		endcase
		return r;
	endfunction

endpackage

/* rtl/arp_front.sv */
// front end: tick and step tracking, pattern lookup for each accepted sample
module arp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic signed [31:0]  sample_in,
	input  logic [2:0]          pattern_select,
	input  logic [15:0]         step_duration,
	output arp_pkg::arp_op_t    op
);
	import arp_pkg::*;

	logic [15:0] tick_q;
	logic [1:0]  step_q;
	logic [2:0]  len;
	logic [1:0]  cur_step;
	logic [1:0]  new_step;
	logic [15:0] tick_nxt;
	logic        adv;

	always_comb begin
		len      = pat_len(pattern_select);
		cur_step = step_mod(step_q, len);
		tick_nxt = tick_q + 16'd1;
		adv      = (tick_nxt >= step_duration);
		new_step = adv ? step_mod(cur_step + 2'd1, len) : cur_step;
		op.sample = sample_in;
		op.factor = pat_mul(pattern_select, new_step);
		op.shift  = pat_shr(pattern_select, new_step);
		op.step   = new_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			step_q <= '0;
		end else if (accept) begin
			tick_q <= adv ? 16'd0 : tick_nxt;
			step_q <= new_step;
		end
	end

	a_tick_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && adv |=> tick_q == 16'd0)
		else $error("tick not cleared at step boundary");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(tick_q) && $stable(step_q))
		else $error("front state changed without a transfer");

endmodule

/* rtl/arp_fifo.sv */
// short queue of classified samples between front and back
module arp_fifo #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  arp_pkg::arp_op_t push_op,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output arp_pkg::arp_op_t pop_op
);
	import arp_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	arp_op_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_op    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("push into full queue");

endmodule

/* rtl/arp_back.sv */
// back end: multiply by factor, arithmetic shift, saturate, output register
module arp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	input  arp_pkg::arp_op_t   op,
	output logic               op_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] sample_out,
	output logic [1:0]         current_step
);
	import arp_pkg::*;

	logic               valid_q;
	logic signed [31:0] sample_q;
	logic [1:0]         step_q;
	logic signed [35:0] prod;
	logic signed [35:0] shifted;
	logic signed [31:0] sat;
	logic               in_range;

	assign op_pop       = op_valid && (!valid_q || out_ready);
	assign out_valid    = valid_q;
	assign sample_out   = sample_q;
	assign current_step = step_q;

	always_comb begin
		prod     = $signed({{4{op.sample[31]}}, op.sample}) * $signed({33'd0, op.factor});
		shifted  = prod >>> op.shift;
		in_range = (shifted[35:31] == 5'b00000) || (shifted[35:31] == 5'b11111);
		if (in_range) begin
			sat = shifted[31:0];
		end else if (shifted[35]) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = 32'sh7FFF_FFFF;
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			sample_q <= sat;
			step_q   <= op.step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	a_pop_refills: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |=> valid_q)
		else $error("popped op did not reach output register");

	a_unity: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop && op.factor == 3'd1 && op.shift == 2'd0 |=> sample_q == $past(op.sample))
		else $error("unity ratio changed the sample");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(sample_q) && $stable(step_q))
		else $error("stalled result lost");

endmodule

/* rtl/arpeggio_ratio_stepper.sv */
// top level of the arpeggio ratio stepper: config registers, front, queue and back
// Scales each signed 32-bit sample by the factor and right shift of the current step of
// one of eight fixed ratio patterns, saturating to 32 bits, and reports the step used.
// The step advances every step_duration samples (0 or 1: every sample). One sample is
// taken per clock cycle while the queue is not full; a result becomes valid in the
// output register after passing through the queue. The front end updates its tick
// and step registers and pushes into a FIFO_DEPTH-entry queue; the back end does the
// multiply, shift and saturation combinationally into the output register,
// so each side can stall on its own. Registers sit at byte addresses 0 (pattern_select)
// and 4 (step_duration); write them only while no sample is in flight.
module arpeggio_ratio_stepper #(
	parameter int FIFO_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] sample_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] sample_out,
	output logic [1:0]         current_step
);
	import arp_pkg::*;

	logic [2:0]  pattern_select_q;
	logic [15:0] step_duration_q;
	logic        wr_en;
	arp_reg_t    reg_sel;
	logic        accept;
	logic        fifo_full;
	logic        fifo_not_empty;
	logic        fifo_pop;
	arp_op_t     front_op;
	arp_op_t     queue_op;

	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite && pready;
	assign reg_sel  = arp_reg_t'(paddr[2]);
	assign in_ready = !fifo_full;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_select_q <= '0;
			step_duration_q  <= STEP_DURATION_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_PATTERN_SELECT: pattern_select_q <= pwdata[2:0];
				REG_STEP_DURATION:  step_duration_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_PATTERN_SELECT: prdata = {29'd0, pattern_select_q};
			REG_STEP_DURATION:  prdata = {16'd0, step_duration_q};
			default:            prdata = '0;
		endcase
	end

	arp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.sample_in      (sample_in),
		.pattern_select (pattern_select_q),
		.step_duration  (step_duration_q),
		.op             (front_op)
	);

	arp_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_op   (front_op),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.not_empty (fifo_not_empty),
		.pop_op    (queue_op)
	);

	arp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (fifo_not_empty),
		.op           (queue_op),
		.op_pop       (fifo_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_out   (sample_out),
		.current_step (current_step)
	);

endmodule

/* test/arp_ratio_checker.sv */
`timescale 1ns / 1ps
// checker for the arpeggio ratio stepper: follows register writes, predicts each result, compares
module arp_ratio_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] sample_in,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] sample_out,
	input  logic [1:0]         current_step,
	output int                 mismatches,
	output int                 outstanding
);
	import arp_pkg::*;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam int REPORT_LINES = 50;

	typedef struct packed {
		logic [2:0]  len;
		logic [11:0] mul;
		logic [7:0]  shr;
	} ratio_row_t;

	typedef struct packed {
		logic signed [31:0] sample;
		logic [1:0]         step;
	} scaled_t;

	scaled_t     expected_scaled [$];
	logic [2:0]  pattern_sel;
	logic [15:0] duration;
	logic [15:0] tick_cnt;
	logic [3:0]  step_idx;
	int          fail_count = 0;

	assign mismatches = fail_count;

	// factors and shifts listed from the last step down to the first
	function automatic ratio_row_t ratio_row(input logic [2:0] sel);
		ratio_row_t r;
		case (sel)
			3'd0:    r = {3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 2'd0, 2'd0, 2'd0, 2'd0};
			3'd1:    r = {3'd2, 3'd0, 3'd0, 3'd2, 3'd1, 2'd0, 2'd0, 2'd0, 2'd0};
			3'd2:    r = {3'd2, 3'd0, 3'd0, 3'd3, 3'd1, 2'd0, 2'd0, 2'd1, 2'd0};
			3'd3:    r = {3'd3, 3'd0, 3'd4, 3'd2, 3'd1, 2'd0, 2'd0, 2'd0, 2'd0};
			3'd4:    r = {3'd3, 3'd0, 3'd2, 3'd3, 3'd1, 2'd0, 2'd0, 2'd1, 2'd0};
			3'd5:    r = {3'd4, 3'd3, 3'd2, 3'd3, 3'd1, 2'd1, 2'd0, 2'd1, 2'd0};
			3'd6:    r = {3'd4, 3'd3, 3'd2, 3'd3, 3'd1, 2'd0, 2'd0, 2'd1, 2'd0};
			default: r = {3'd4, 3'd2, 3'd3, 3'd5, 3'd1, 2'd0, 2'd1, 2'd2, 2'd0};
		endcase
		return r;
	endfunction

	function automatic scaled_t predict_scaled(input logic signed [31:0] x);
		ratio_row_t r;
		int         n;
		int         st;
		longint     prod;
		scaled_t    res;
		r = ratio_row(pattern_sel);
		n = r.len;
		st = step_idx % n;
		tick_cnt = tick_cnt + 16'd1;
		if (tick_cnt >= duration) begin
			st = (st + 1) % n;
			tick_cnt = '0;
		end
		step_idx = st[3:0];
		prod = longint'(x) * longint'(r.mul[st*3 +: 3]);
		prod = prod >>> r.shr[st*2 +: 2];
		if (prod > S32_MAX)
			prod = S32_MAX;
		else if (prod < S32_MIN)
			prod = S32_MIN;
		res.sample = prod[31:0];
		res.step = st[1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint want, input longint got);
		fail_count++;
		if (fail_count <= REPORT_LINES)
			$display("%0t mismatch: %s expected %0d got %0d", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		scaled_t want;
		if (!arst_n) begin
			pattern_sel = '0;
			duration = STEP_DURATION_RESET;
			tick_cnt = '0;
			step_idx = '0;
			expected_scaled.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (arp_reg_t'(paddr[2]))
					REG_PATTERN_SELECT: pattern_sel = pwdata[2:0];
					REG_STEP_DURATION:  duration = pwdata[15:0];
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_scaled.size() == 0) begin
					report_mismatch("result with nothing pending, sample_out", 0, sample_out);
				end else begin
					want = expected_scaled.pop_front();
					if (sample_out !== want.sample)
						report_mismatch("sample_out", want.sample, sample_out);
					if (current_step !== want.step)
						report_mismatch("current_step", want.step, current_step);
				end
			end
			if (in_valid && in_ready)
				expected_scaled.push_back(predict_scaled(sample_in));
			outstanding <= expected_scaled.size();
		end
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// testbench top for the arpeggio ratio stepper: clock, reset, stimulus, register phases, verdict
module tb_top;
	import arp_pkg::*;

	localparam int ITEM_TARGET  = 1800;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int LONG_HOLD    = 60;
	localparam int HOLD_AFTER   = 400;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] sample_in;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] sample_out;
	logic [1:0]         current_step;
	int                 mismatches;
	int                 outstanding;
	int                 sent = 0;
	logic               sender_burst = 1'b0;

	arpeggio_ratio_stepper u_top (.*);

	arp_ratio_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic apb_write(input arp_reg_t r, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(input logic signed [31:0] value);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= value;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_phase(input logic [2:0] sel, input logic [15:0] dur, input bit write_dur);
		wait_drained();
		apb_write(REG_PATTERN_SELECT, {29'd0, sel});
		if (write_dur)
			apb_write(REG_STEP_DURATION, {16'd0, dur});
	endtask

	function automatic logic signed [31:0] draw_sample();
		logic signed [31:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'sh7fffffff;
			1: v = 32'sh80000000;
			2: v = $signed($urandom_range(0, 2)) - 1;
			3: v = $signed($urandom_range(0, 511)) - 256;
			4: begin
				// near the saturation points of the factors
				case ($urandom_range(0, 3))
					0:       v = 32'sh33333333;
					1:       v = 32'sh2aaaaaaa;
					2:       v = 32'sh40000000;
					default: v = 32'sh55555555;
				endcase
				v = v + $signed($urandom_range(0, 6)) - 3;
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] draw_duration();
		case ($urandom_range(0, 9))
			0:       return 16'd0;
			1:       return 16'd1;
			2:       return 16'hffff;
			3:       return STEP_DURATION_RESET;
			4:       return 16'($urandom);
			default: return 16'($urandom_range(2, 12));
		endcase
	endfunction

	initial begin : stimulus
		int phase;
		int count;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		sample_in <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: single-step pattern, long duration
		send_sample(32'sh7fffffff);
		send_sample(32'sh80000000);
		send_sample(32'sd0);
		send_sample(-32'sd1);

		// largest factors, a step on every sample, saturation both ways
		set_phase(3'd7, 16'd1, 1'b1);
		send_sample(32'sh7fffffff);
		send_sample(32'sh80000000);
		send_sample(32'sh7fffffff);
		send_sample(-32'sd1);
		send_sample(32'sh80000000);
		send_sample(-32'sd1);
		send_sample(32'sd1);

		// switch to a shorter pattern while on the last step, zero duration
		set_phase(3'd2, 16'd0, 1'b1);
		send_sample(32'sd5);
		send_sample(-32'sd5);
		send_sample(32'sh7fffffff);
		send_sample(32'sh80000000);

		set_phase(3'd4, 16'd3, 1'b1);
		send_sample(32'sh40000000);
		send_sample(-32'sh40000000);
		send_sample(32'sh2aaaaaab);
		send_sample(32'sh55555555);
		send_sample(-32'sd7);
		send_sample(32'sd7);

		set_phase(3'd6, 16'hffff, 1'b1);
		send_sample(32'sh80000000);
		send_sample(32'sh7fffffff);
		send_sample(32'sd123);

		phase = 0;
		while (sent < ITEM_TARGET) begin
			set_phase(phase < 8 ? 3'(phase) : 3'($urandom), draw_duration(),
				phase < 8 || $urandom_range(0, 3) != 0);
			sender_burst = ($urandom_range(0, 3) == 0);
			count = $urandom_range(10, 80);
			repeat (count) send_sample(draw_sample());
			phase++;
		end

		wait_drained();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : receiver
		int wait_cycles;
		int calm_left;
		int taken;
		bit hold_done;
		calm_left = 0;
		taken = 0;
		hold_done = 1'b0;
		forever begin
			if (!hold_done && taken >= HOLD_AFTER && in_valid) begin
				// long stall so the queue fills and the input backs up
				wait_cycles = LONG_HOLD;
				hold_done = 1'b1;
			end else if (calm_left > 0) begin
				wait_cycles = 0;
				calm_left--;
			end else begin
				wait_cycles = $urandom_range(0, 8);
				if ($urandom_range(0, 15) == 0)
					calm_left = 30;
			end
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			taken++;
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

endmodule

/* filelist.f */
rtl/arp_pkg.sv
rtl/arp_front.sv
rtl/arp_fifo.sv
rtl/arp_back.sv
rtl/arpeggio_ratio_stepper.sv
test/arp_ratio_checker.sv
test/tb_top.sv
